>>> hw/rtl/lzwd_pkg.sv
// shared constants and controller/datapath handshake types for the lz window decompressor
`default_nettype none
package lzwd_pkg;

  localparam int WINDOW_DEPTH  = 4096;
  localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 24;
  localparam int LEN_W         = 4;
  localparam int MAX_TOKEN_LEN = (1 << LEN_W) - 1;
  localparam int IDX_W         = $clog2(MAX_TOKEN_LEN);

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // latch token, apply start of stream
    logic prep;   // check limits, issue first window read
    logic step;   // emit one byte into the output register
  } lzwd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic skip;       // token emits nothing
    logic last;       // current byte ends the token
    logic slot_free;  // output register can take a byte
  } lzwd_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/lzwd_in_if.sv
// token input channel: valid/ready with the two token bytes and start flag
`default_nettype none
interface lzwd_in_if;
  import lzwd_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_of_stream;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;

  modport source (output valid, output start_of_stream, output first_byte,
                  output second_byte, input ready);
  modport sink   (input valid, input start_of_stream, input first_byte,
                  input second_byte, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lzwd_out_if.sv
// byte output channel: valid/ready with the decompressed byte and its flags
`default_nettype none
interface lzwd_out_if;
  import lzwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_token;
  logic              stream_done;
  logic              bad_reference;

  modport source (output valid, output out_byte, output last_of_token,
                  output stream_done, output bad_reference, input ready);
  modport sink   (input valid, input out_byte, input last_of_token,
                  input stream_done, input bad_reference, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lz_window_decompressor.sv
// lz window decompressor top level: token channel in, byte channel out
// first byte of a token: latched when taken, first window read issued in the prep state,
//   then loaded into the output register in the emit state once the output slot is free
// bytes go out one byte per cycle off the single window read port, stalled by out ready
// a token that emits nothing (limit reached, zero length) goes from prep back to idle
// reset clears produced count, done flag and out_length; the window is not cleared
`default_nettype none
module lz_window_decompressor
  import lzwd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  lzwd_in_if.sink               in_ch,
  lzwd_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  lzwd_cmd_t cmd;
  lzwd_sts_t sts;

  // controller
  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  lzwd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tok_sos   (in_ch.start_of_stream),
    .tok_b1    (in_ch.first_byte),
    .tok_b2    (in_ch.second_byte),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_token),
    .out_done  (out_ch.stream_done),
    .out_bad   (out_ch.bad_reference)
  );

endmodule
`default_nettype wire

>>> hw/rtl/lzwd_ctrl.sv
// controller state machine: sequences token load, limit check and byte emission
`default_nettype none
module lzwd_ctrl
  import lzwd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lzwd_sts_t sts,
  output lzwd_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.skip ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lzwd_datapath.sv
// datapath: token registers, history window, produced count and output register
`default_nettype none
module lzwd_datapath
  import lzwd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lzwd_cmd_t         cmd,
  output lzwd_sts_t              sts,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  // token payload
  input  wire logic              tok_sos,
  input  wire logic [BYTE_W-1:0] tok_b1,
  input  wire logic [BYTE_W-1:0] tok_b2,
  // output register
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last,
  output logic                   out_done,
  output logic                   out_bad
);

  logic [CNT_W-1:0]  out_length_r;
  logic [CNT_W-1:0]  count_r;
  logic              done_r;
  logic [BYTE_W-1:0] b1_r;
  logic [BYTE_W-1:0] b2_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WIN_AW-1:0] rd_ptr_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] tokbuf_r [MAX_TOKEN_LEN];
  logic [BYTE_W-1:0] window_mem [WINDOW_DEPTH];

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_done_r;
  logic              out_bad_r;

  logic              is_lit;
  logic [LEN_W-1:0]  tok_len;
  logic [WIN_AW-1:0] back_dist;
  logic              limit_hit;
  logic              bad;
  logic              from_buf;
  logic [IDX_W-1:0]  buf_idx;
  logic [BYTE_W-1:0] byte_val;
  logic [CNT_W-1:0]  count_inc;
  logic              done_new;
  logic              last;
  logic              rd_en;
  logic [WIN_AW-1:0] rd_addr;

  // token decode
  assign is_lit    = (b1_r == '0);
  assign tok_len   = is_lit ? LEN_W'(1) : b1_r[BYTE_W-1 -: LEN_W];
  assign back_dist = {b1_r[LEN_W-1:0], b2_r};

  // limit check before a token runs
  assign limit_hit = done_r || (count_r >= out_length_r);

  // per-byte reference check and source select
  assign bad      = !is_lit && ((back_dist == '0) ||
                    ({{(CNT_W-WIN_AW){1'b0}}, back_dist} > count_r));
  assign from_buf = (back_dist <= {{(WIN_AW-IDX_W){1'b0}}, idx_r});
  assign buf_idx  = idx_r - back_dist[IDX_W-1:0];

  always_comb begin
    if (is_lit) begin
      byte_val = b2_r;
    end else if (bad) begin
      byte_val = '0;
    end else if (from_buf) begin
      byte_val = tokbuf_r[buf_idx];
    end else begin
      byte_val = rd_data_r;
    end
  end

  assign count_inc = count_r + CNT_W'(1);
  assign done_new  = (count_inc >= out_length_r);
  assign last      = (idx_r == tok_len - LEN_W'(1)) || done_new;

  // window read: first byte on prep, then one ahead of each emitted byte
  assign rd_en   = cmd.prep || cmd.step;
  assign rd_addr = cmd.prep ? (count_r[WIN_AW-1:0] - back_dist) : rd_ptr_r;

  assign sts.skip      = limit_hit || (tok_len == '0);
  assign sts.last      = last;
  assign sts.slot_free = !out_valid_r || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_length_r <= '0;
    end else if (cfg_we) begin
      out_length_r <= cfg_wdata;
    end
  end

  // produced count and done flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else if (cmd.load && tok_sos) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else if (cmd.prep && limit_hit) begin
      done_r  <= 1'b1;
    end else if (cmd.step) begin
      count_r <= count_inc;
      done_r  <= done_new;
    end
  end

  // token registers, byte index and read pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b1_r <= tok_b1;
      b2_r <= tok_b2;
    end
    if (cmd.prep) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (rd_en) begin
      rd_ptr_r <= rd_addr + WIN_AW'(1);
    end
  end

  // bytes of the current token, for copies that overlap themselves
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      tokbuf_r[idx_r] <= byte_val;
    end
  end

  // history window
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      window_mem[count_r[WIN_AW-1:0]] <= byte_val;
    end
    if (rd_en) begin
      rd_data_r <= window_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte_r <= byte_val;
      out_last_r <= last;
      out_done_r <= done_new;
      out_bad_r  <= bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;
  assign out_bad   = out_bad_r;

endmodule
`default_nettype wire

>>> hw/rtl/lzwd_checker.sv
// port-level checker for the lz window decompressor, bound to the top level
`default_nettype none
module lzwd_checker
  import lzwd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              out_last,
  input wire logic              out_done,
  input wire logic              out_bad
);

  // a stalled byte stays offered unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output byte dropped or changed while stalled");

  // a bad reference always emits zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad |-> out_byte == '0)
    else $error("bad reference with nonzero byte");

  // reaching the length ends the token
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_last)
    else $error("stream done without last of token");

  // one token at a time: no new transaction right after one is taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

endmodule

bind lz_window_decompressor lzwd_checker u_lzwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_of_token),
  .out_done  (out_ch.stream_done),
  .out_bad   (out_ch.bad_reference)
);
`default_nettype wire

>>> dv/lz_window_decompressor_test.sv
// testbench for the lz window decompressor: directed token table, random streams, byte checks
`timescale 1ns / 100ps
module lz_window_decompressor_test;
  import lzwd_pkg::*;

  localparam int STALL_LIMIT = 1000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int SETTLE      = 8;     // covers a token that emits nothing
  localparam int PHASE_TOKENS = 24;
  localparam int RUN_TOKENS   = 116;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
    logic              bad;
  } byte_rec_t;

  typedef enum logic [1:0] {ROW_TOKEN, ROW_SETLEN} row_kind_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct packed {
    row_kind_t         kind;
    row_check_t        chk;
    logic              sos;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [CNT_W-1:0]  value;
    byte_rec_t         golden;
  } row_t;

  localparam byte_rec_t NO_BYTE = '0;

  // directed table: golden bytes only where the answer is obvious
  localparam row_t PLAN [27] = '{
    // out_length still 0 after reset: nothing comes out
    '{ROW_TOKEN,  CHK_NONE,    1'b1, 8'h00, 8'h5A, 24'd0, NO_BYTE},
    '{ROW_SETLEN, CHK_NONE,    1'b0, 8'h00, 8'h00, 24'd40, NO_BYTE},
    '{ROW_TOKEN,  CHK_ONE,     1'b1, 8'h00, 8'hFF, 24'd0, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{ROW_TOKEN,  CHK_ONE,     1'b0, 8'h00, 8'h00, 24'd0, '{8'h00, 1'b1, 1'b0, 1'b0}},
    // distance zero, then distance far beyond the produced count
    '{ROW_TOKEN,  CHK_ONE,     1'b0, 8'h10, 8'h00, 24'd0, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{ROW_TOKEN,  CHK_ONE,     1'b0, 8'h1F, 8'hFF, 24'd0, '{8'h00, 1'b1, 1'b0, 1'b1}},
    // zero length nibble
    '{ROW_TOKEN,  CHK_NONE,    1'b0, 8'h01, 8'h02, 24'd0, NO_BYTE},
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'h33, 8'h00, 24'd0, NO_BYTE},
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'hF0, 8'h01, 24'd0, NO_BYTE},
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'hF0, 8'h04, 24'd0, NO_BYTE},
    // runs past out_length and is cut short
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'h50, 8'h02, 24'd0, NO_BYTE},
    '{ROW_TOKEN,  CHK_NONE,    1'b0, 8'h00, 8'h11, 24'd0, NO_BYTE},
    // raising the length does not clear done
    '{ROW_SETLEN, CHK_NONE,    1'b0, 8'h00, 8'h00, 24'd100, NO_BYTE},
    '{ROW_TOKEN,  CHK_NONE,    1'b0, 8'h00, 8'h22, 24'd0, NO_BYTE},
    '{ROW_TOKEN,  CHK_ONE,     1'b1, 8'h00, 8'h80, 24'd0, '{8'h80, 1'b1, 1'b0, 1'b0}},
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'h20, 8'h01, 24'd0, NO_BYTE},
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'h40, 8'h03, 24'd0, NO_BYTE},
    // first byte bad, second byte reaches back to the stream start
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'h20, 8'h08, 24'd0, NO_BYTE},
    '{ROW_SETLEN, CHK_NONE,    1'b0, 8'h00, 8'h00, 24'hFFFFFF, NO_BYTE},
    '{ROW_TOKEN,  CHK_ONE,     1'b1, 8'h00, 8'h01, 24'd0, '{8'h01, 1'b1, 1'b0, 1'b0}},
    '{ROW_TOKEN,  CHK_PREDICT, 1'b0, 8'hFF, 8'hFF, 24'd0, NO_BYTE},
    // length lowered under the produced count
    '{ROW_SETLEN, CHK_NONE,    1'b0, 8'h00, 8'h00, 24'd5, NO_BYTE},
    '{ROW_TOKEN,  CHK_NONE,    1'b0, 8'h00, 8'h33, 24'd0, NO_BYTE},
    '{ROW_SETLEN, CHK_NONE,    1'b0, 8'h00, 8'h00, 24'd1, NO_BYTE},
    '{ROW_TOKEN,  CHK_ONE,     1'b1, 8'h00, 8'h44, 24'd0, '{8'h44, 1'b1, 1'b1, 1'b0}},
    // match cut to one bad byte by the length
    '{ROW_TOKEN,  CHK_ONE,     1'b1, 8'h31, 8'h00, 24'd0, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{ROW_TOKEN,  CHK_NONE,    1'b1, 8'h0F, 8'h00, 24'd0, NO_BYTE}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  lzwd_in_if  in_ch ();
  lzwd_out_if out_ch ();

  lz_window_decompressor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decompressor state as the block should hold it
  logic [BYTE_W-1:0] history [WINDOW_DEPTH];
  logic [CNT_W-1:0]  bytes_made   = '0;
  logic              stream_over  = 1'b0;
  logic [CNT_W-1:0]  length_limit = '0;

  byte_rec_t token_bytes [$];     // bytes of the token just accepted
  byte_rec_t expected_bytes [$];  // bytes still owed by the block
  int        mismatches = 0;

  logic steady   = 1'b0;  // no idling on either side
  logic hold_req = 1'b0;  // ask the receiver for its long hold-off

  // write one byte into the window and the token's result list
  function automatic void put_byte(input logic [BYTE_W-1:0] val, input logic bad);
    history[bytes_made[WIN_AW-1:0]] = val;
    bytes_made = bytes_made + 1'b1;
    if (bytes_made >= length_limit) stream_over = 1'b1;
    token_bytes.push_back('{val, 1'b0, stream_over, bad});
  endfunction

  // expand one token into the bytes it produces
  function automatic void expand_token(input logic sos, input logic [BYTE_W-1:0] b1,
                                       input logic [BYTE_W-1:0] b2);
    logic [LEN_W-1:0]  run_len;
    logic [WIN_AW-1:0] back_dist;
    logic [CNT_W-1:0]  rd_pos;
    logic              bad;
    byte_rec_t         tail;
    token_bytes.delete();
    if (sos) begin
      bytes_made  = '0;
      stream_over = 1'b0;
    end
    if (stream_over || bytes_made >= length_limit) begin
      stream_over = 1'b1;
      return;
    end
    if (b1 == 8'h00) begin
      put_byte(b2, 1'b0);
    end else begin
      run_len   = b1[7:4];
      back_dist = {b1[3:0], b2};
      for (int i = 0; i < run_len && !stream_over; i++) begin
        bad    = (back_dist == '0) || (CNT_W'(back_dist) > bytes_made);
        rd_pos = bytes_made - CNT_W'(back_dist);
        put_byte(bad ? 8'h00 : history[rd_pos[WIN_AW-1:0]], bad);
      end
    end
    if (token_bytes.size() > 0) begin
      tail = token_bytes.pop_back();
      tail.last = 1'b1;
      token_bytes.push_back(tail);
    end
  endfunction

  // random token, mostly well-formed against the current stream
  function automatic void pick_token(input bit long_run, input bit fresh, output logic sos,
                                     output logic [BYTE_W-1:0] b1,
                                     output logic [BYTE_W-1:0] b2);
    int               roll;
    int               made;
    int               max_d;
    logic [LEN_W-1:0] run_len;
    logic [11:0]      ref_dist;
    sos = fresh || (stream_over && $urandom_range(3) == 0) || $urandom_range(49) == 0;
    made  = sos ? 0 : int'(bytes_made);
    max_d = made > 4095 ? 4095 : made;
    if (long_run) roll = ($urandom_range(99) < 95) ? 40 : 0;
    else roll = $urandom_range(99);
    run_len = long_run ? 4'hF : 4'($urandom_range(15, 1));
    if (roll < 35 || (roll < 85 && max_d == 0)) begin
      // literal
      b1 = 8'h00;
      b2 = 8'($urandom_range(255));
    end else if (roll < 85) begin
      // copy from inside the history, often close by
      if ($urandom_range(1) == 1) ref_dist = 12'($urandom_range(max_d, 1));
      else ref_dist = 12'($urandom_range(max_d < 16 ? max_d : 16, 1));
      b1 = {run_len, ref_dist[11:8]};
      b2 = ref_dist[7:0];
    end else if (roll < 92) begin
      // broken reference
      if (made >= 4095 || $urandom_range(2) == 0) ref_dist = '0;
      else ref_dist = 12'($urandom_range(4095, made + 1));
      b1 = {run_len, ref_dist[11:8]};
      b2 = ref_dist[7:0];
    end else if (roll < 96) begin
      // zero length nibble
      b1 = {4'h0, 4'($urandom_range(15, 1))};
      b2 = 8'($urandom_range(255));
    end else begin
      b1 = 8'($urandom_range(255));
      b2 = 8'($urandom_range(255));
    end
  endfunction

  // compare one output transaction with the oldest owed byte
  function automatic void check_byte(input byte_rec_t got);
    byte_rec_t want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected byte: data %h last %b done %b bad %b",
               $time, got.data, got.last, got.done, got.bad);
      return;
    end
    want = expected_bytes.pop_front();
    if (got !== want) begin
      mismatches++;
      $display("%0t: byte mismatch: expected data %h last %b done %b bad %b",
               $time, want.data, want.last, want.done, want.bad);
      $display("%0t:                  actual data %h last %b done %b bad %b",
               $time, got.data, got.last, got.done, got.bad);
    end
  endfunction

  // offer one token, return at the edge that accepts it
  task automatic send_token(input logic sos, input logic [BYTE_W-1:0] b1,
                            input logic [BYTE_W-1:0] b2);
    if (!steady && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.start_of_stream <= sos;
    in_ch.first_byte      <= b1;
    in_ch.second_byte     <= b2;
    do @(posedge clk); while (!in_ch.ready);
    expand_token(sos, b1, b2);
  endtask

  // stop offering until every owed byte is out and the block has settled
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_out_length(input logic [CNT_W-1:0] len);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we       <= 1'b0;
    length_limit = len;
  endtask

  // receiver: check every transaction, random ready, one long hold-off
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        check_byte('{out_ch.out_byte, out_ch.last_of_token, out_ch.stream_done,
                     out_ch.bad_reference});
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stalled = 0;
      else stalled++;
    end
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    logic             sos;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [CNT_W-1:0]  len;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.start_of_stream <= 1'b0;
    in_ch.first_byte      <= '0;
    in_ch.second_byte     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_SETLEN) begin
        set_out_length(PLAN[r].value);
      end else begin
        send_token(PLAN[r].sos, PLAN[r].b1, PLAN[r].b2);
        case (PLAN[r].chk)
          CHK_ONE:     expected_bytes.push_back(PLAN[r].golden);
          CHK_PREDICT: foreach (token_bytes[j]) expected_bytes.push_back(token_bytes[j]);
          default: ;
        endcase
      end
    end

    // random streams under several lengths
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(7))
        0:       len = 24'($urandom_range(24, 1));
        1:       len = 24'hFFFFFF;
        default: len = 24'($urandom_range(600, 60));
      endcase
      set_out_length(len);
      steady <= (ph == 2);
      if (ph == 0) hold_req <= 1'b1;
      for (int k = 0; k < PHASE_TOKENS; k++) begin
        if (ph == 1 && k == PHASE_TOKENS / 2) wait_quiet();
        pick_token(1'b0, k == 0 && $urandom_range(3) != 0, sos, b1, b2);
        send_token(sos, b1, b2);
        foreach (token_bytes[j]) expected_bytes.push_back(token_bytes[j]);
      end
    end

    // one long stream of mostly full-length copies, back to back
    set_out_length(24'hFFFFFF);
    steady <= 1'b1;
    for (int k = 0; k < RUN_TOKENS; k++) begin
      pick_token(1'b1, k == 0, sos, b1, b2);
      send_token(sos && k == 0, b1, b2);
      foreach (token_bytes[j]) expected_bytes.push_back(token_bytes[j]);
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
